// File: hw/rtl/linear_gain_ramp_fader_core_assert.svh
// Assertion macros used by the fader core RTL.
`ifndef LINEAR_GAIN_RAMP_FADER_CORE_ASSERT_SVH
`define LINEAR_GAIN_RAMP_FADER_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LGRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgrf assertion failed (same cycle)");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LGRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgrf assertion failed (next cycle)");

`endif

// File: hw/rtl/lgrf_pkg.sv
`timescale 1ns / 1ps

package lgrf_pkg;

   localparam int SAMPLE_W = 24;
   localparam int TARGET_W = 17;
   localparam int RATE_W   = 16;
   localparam int GAIN_W   = 31;
   localparam int STEP_W   = 32;

   localparam logic [TARGET_W-1:0] TARGET_MAX = 17'd65536;
   localparam logic [RATE_W-1:0]   RATE_RESET = 16'd64;
   localparam logic [GAIN_W-1:0]   GAIN_ONE   = 31'h4000_0000;

   // Request from the pipeline to the gain tracker for one item.
   typedef struct packed {
      logic                advance;
      logic [TARGET_W-1:0] target;
   } gain_req_type;

endpackage

// File: hw/rtl/linear_gain_ramp_fader_core.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+----------------------------------------
// req       | in        | req_valid/req_stall | sample_in, target_gain, block_end
// rsp       | out       | rsp_valid/rsp_stall | sample_out, gain_now, last
// csr       | in        | csr_wr_en          | csr_wr_data (ramp rate, Q0.16)
//
// One item per cycle is sustained while rsp is not stalled; each item passes an
// input register, the gain stage and the result register, in that order, and
// leaves on rsp from the result register.
// The gain update runs from the gain register through the step multiply and back into it.
// Reset is synchronous and active high; it empties the pipeline, zeroes the ramp
// state and loads a ramp rate of 64. A stall on rsp backs up stage by stage, and
// req_stall rises only when all three stages hold an item.

module linear_gain_ramp_fader_core (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lgrf_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic [lgrf_pkg::TARGET_W-1:0]          req_target_gain,
   input  logic                                   req_block_end,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lgrf_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic [lgrf_pkg::TARGET_W-1:0]          rsp_gain_now,
   output logic                                   rsp_last,

   input  logic                                   csr_wr_en,
   input  logic [lgrf_pkg::RATE_W-1:0]            csr_wr_data
);

   `include "linear_gain_ramp_fader_core_assert.svh"

   // Ramp rate register.
   logic [lgrf_pkg::RATE_W-1:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= lgrf_pkg::RATE_RESET;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   // Stage 0: the input register. Stage 1: gain applied to this item.
   // Stage 2: the result register that drives the rsp channel.
   logic                                 v0_ff, v1_ff, v2_ff;
   logic signed [lgrf_pkg::SAMPLE_W-1:0] sample0_ff, sample1_ff, sample2_ff;
   logic [lgrf_pkg::TARGET_W-1:0]        target0_ff;
   logic                                 last0_ff, last1_ff, last2_ff;
   logic [lgrf_pkg::GAIN_W-1:0]          gain1_ff;
   logic [lgrf_pkg::TARGET_W-1:0]        gain2_ff;

   logic ready0, ready1, ready2;
   logic accept_in, move01, move12;

   // Each stage may take a new item when it is empty or its item moves on
   // in the same cycle.
   always_comb begin
      ready2    = !v2_ff || !rsp_stall;
      ready1    = !v1_ff || ready2;
      ready0    = !v0_ff || ready1;
      accept_in = req_valid && ready0;
      move01    = v0_ff && ready1;
      move12    = v1_ff && ready2;
   end

   assign req_stall = !ready0;

   // The gain tracker updates its state exactly once per item, as the item
   // leaves the input register, so items see the ramp in arrival order.
   lgrf_pkg::gain_req_type        trk_req;
   logic [lgrf_pkg::GAIN_W-1:0]   gain_next;

   always_comb begin
      trk_req.advance = move01;
      trk_req.target  = target0_ff;
   end

   lgrf_gain_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .rate      (rate_ff),
      .req       (trk_req),
      .gain_next (gain_next)
   );

   // Output arithmetic: sample (Q1.23) times gain (Q1.30), rounded half up at
   // bit 30, then saturated to the 24-bit sample range.
   logic signed [55:0]                    prod;
   logic signed [55:0]                    rounded;
   logic signed [25:0]                    scaled;
   logic signed [lgrf_pkg::SAMPLE_W-1:0]  sat_in;

   always_comb begin
      prod    = 56'(sample1_ff) * 56'($signed({1'b0, gain1_ff}));
      rounded = prod + 56'sh2000_0000;
      scaled  = rounded[55:30];
      if (scaled > 26'sd8388607) begin
         sat_in = 24'sh7F_FFFF;
      end else if (scaled < -26'sd8388608) begin
         sat_in = 24'sh80_0000;
      end else begin
         sat_in = scaled[23:0];
      end
   end

   // Valid bits are control state and are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready0) begin
            v0_ff <= req_valid;
         end
         if (ready1) begin
            v1_ff <= v0_ff;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   // Payload registers load only when an item moves in, so a stalled result
   // holds its value.
   always_ff @(posedge clock) begin
      if (accept_in) begin
         sample0_ff <= req_sample_in;
         target0_ff <= req_target_gain;
         last0_ff   <= req_block_end;
      end
      if (move01) begin
         sample1_ff <= sample0_ff;
         gain1_ff   <= gain_next;
         last1_ff   <= last0_ff;
      end
      if (move12) begin
         sample2_ff <= sat_in;
         gain2_ff   <= gain1_ff[30:14];
         last2_ff   <= last1_ff;
      end
   end

   assign rsp_valid      = v2_ff;
   assign rsp_sample_out = sample2_ff;
   assign rsp_gain_now   = gain2_ff;
   assign rsp_last       = last2_ff;

   // An item that is accepted lands in the input register.
   `LGRF_ASSERT_NEXT(a_accept_lands, clock, reset, accept_in, v0_ff)
   // An item in the gain stage is never dropped while the result is stalled.
   `LGRF_ASSERT_NEXT(a_stage1_held, clock, reset, v1_ff && v2_ff && rsp_stall, v1_ff)
   // The reported gain never goes above unity.
   `LGRF_ASSERT_NOW(a_gain_bound, clock, reset, rsp_valid, rsp_gain_now <= lgrf_pkg::TARGET_MAX)

endmodule

// File: hw/rtl/lgrf_gain_tracker.sv
`timescale 1ns / 1ps

// Holds the ramp state and computes the gain for the item that advances.
module lgrf_gain_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lgrf_pkg::RATE_W-1:0]        rate,
   input  lgrf_pkg::gain_req_type             req,
   output logic [lgrf_pkg::GAIN_W-1:0]        gain_next
);

   logic [lgrf_pkg::GAIN_W-1:0]          gain_ff, gain_in;
   logic signed [lgrf_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [lgrf_pkg::TARGET_W-1:0]        held_ff, held_in;

   logic [lgrf_pkg::TARGET_W-1:0]        tgt_sat;
   logic [lgrf_pkg::GAIN_W-1:0]          tgt_q30;
   logic signed [31:0]                   diff;
   logic [30:0]                          mag;
   logic [46:0]                          prod;
   logic [30:0]                          st;
   logic signed [lgrf_pkg::STEP_W-1:0]   step_sel;
   logic signed [32:0]                   sum;
   logic signed [32:0]                   tgt_ext;
   logic                                 reached;

   always_comb begin
      tgt_sat = (req.target > lgrf_pkg::TARGET_MAX) ? lgrf_pkg::TARGET_MAX : req.target;
      tgt_q30 = {tgt_sat, 14'b0};
      diff    = $signed({1'b0, tgt_q30}) - $signed({1'b0, gain_ff});
      mag     = diff[31] ? 31'(-diff) : diff[30:0];
      prod    = 47'(mag) * 47'(rate);
      st      = prod[46:16];
      // A tiny distance still moves by one LSB when the rate is nonzero, so the ramp finishes.
      if ((st == 31'd0) && (mag != 31'd0) && (rate != '0)) begin
         st = 31'd1;
      end

      if (tgt_sat != held_ff) begin
         step_sel = diff[31] ? -$signed({1'b0, st}) : $signed({1'b0, st});
      end else begin
         step_sel = step_ff;
      end

      sum     = $signed({2'b0, gain_ff}) + $signed({step_sel[31], step_sel});
      tgt_ext = $signed({2'b0, tgt_q30});
      reached = (!step_sel[31] && (sum >= tgt_ext)) || (step_sel[31] && (sum <= tgt_ext));

      held_in = tgt_sat;
      if (step_sel == '0) begin
         gain_in = gain_ff;
         step_in = '0;
      end else if (reached) begin
         gain_in = tgt_q30;
         step_in = '0;
      end else begin
         step_in = step_sel;
         if (sum < 33'sd0) begin
            gain_in = '0;
         end else if (sum > $signed({2'b0, lgrf_pkg::GAIN_ONE})) begin
            gain_in = lgrf_pkg::GAIN_ONE;
         end else begin
            gain_in = sum[30:0];
         end
      end
      gain_next = gain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         step_ff <= '0;
         held_ff <= '0;
      end else if (req.advance) begin
         gain_ff <= gain_in;
         step_ff <= step_in;
         held_ff <= held_in;
      end
   end

endmodule

// File: sim/linear_gain_ramp_fader_core_tb.sv
`timescale 1ns / 1ps

module linear_gain_ramp_fader_core_tb;

   // The receiver holds off this long when a backpressure burst is requested.
   localparam int  HOLD_CYCLES = 80;
   localparam int  DRAIN_LIMIT = 20000;
   localparam longint HALF_LSB = 64'sd536870912;  // one half in Q1.30 product units
   localparam longint UNITY_Q30 = 64'sd1073741824;
   localparam longint OUT_HI = 64'sd8388607;
   localparam longint OUT_LO = -64'sd8388608;

   typedef struct packed {
      logic signed [lgrf_pkg::SAMPLE_W-1:0] sample_out;
      logic [lgrf_pkg::TARGET_W-1:0]        gain_now;
      logic                                 last;
   } faded_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [lgrf_pkg::SAMPLE_W-1:0] req_sample_in = '0;
   logic [lgrf_pkg::TARGET_W-1:0]        req_target_gain = '0;
   logic                                 req_block_end = 1'b0;

   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [lgrf_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic [lgrf_pkg::TARGET_W-1:0]        rsp_gain_now;
   logic                                 rsp_last;

   logic                                 csr_wr_en = 1'b0;
   logic [lgrf_pkg::RATE_W-1:0]          csr_wr_data = '0;

   // Predictor state, mirroring the ramp registers of the block.
   logic [lgrf_pkg::RATE_W-1:0]   fade_rate = lgrf_pkg::RATE_RESET;
   longint                        gain_q30 = 0;
   int                            step_q30 = 0;
   logic [lgrf_pkg::TARGET_W-1:0] held_target = '0;

   faded_sample_type pending_faded[$];
   faded_sample_type oldest_faded;
   int               error_count = 0;

   // Idling knobs for the two sides and the backpressure request counter.
   bit req_idling = 1'b0;
   bit rsp_idling = 1'b0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;

   always #6 clock = ~clock;

   linear_gain_ramp_fader_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_in   (req_sample_in),
      .req_target_gain (req_target_gain),
      .req_block_end   (req_block_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_gain_now    (rsp_gain_now),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int random_gap_len();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Advances the ramp by one item and queues the faded sample it produces.
   function automatic void predict_faded_sample(
         input logic signed [lgrf_pkg::SAMPLE_W-1:0] smp,
         input logic [lgrf_pkg::TARGET_W-1:0] tgt_in,
         input logic blk);
      logic [lgrf_pkg::TARGET_W-1:0] tgt;
      longint                        tgt_q30;
      longint                        span;
      longint                        span_abs;
      longint                        stride;
      longint                        prod;
      longint                        y;
      faded_sample_type              res;

      tgt = (tgt_in > lgrf_pkg::TARGET_MAX) ? lgrf_pkg::TARGET_MAX : tgt_in;
      tgt_q30 = longint'(tgt) << 14;

      // A new target recomputes the per-sample step from the remaining distance.
      if (tgt != held_target) begin
         span = tgt_q30 - gain_q30;
         span_abs = (span < 0) ? -span : span;
         stride = (span_abs * longint'(fade_rate)) >>> 16;
         // Keep a ramp alive when the truncated step would round to nothing.
         if (stride == 0 && span_abs != 0 && fade_rate != '0) begin
            stride = 1;
         end
         held_target = tgt;
         step_q30 = int'((span < 0) ? -stride : stride);
      end

      if (step_q30 != 0) begin
         gain_q30 += longint'(step_q30);
         if ((step_q30 > 0 && gain_q30 >= tgt_q30) || (step_q30 < 0 && gain_q30 <= tgt_q30)) begin
            gain_q30 = tgt_q30;
            step_q30 = 0;
         end
      end
      if (gain_q30 < 0) begin
         gain_q30 = 0;
      end
      if (gain_q30 > UNITY_Q30) begin
         gain_q30 = UNITY_Q30;
      end

      // Round to nearest with ties upward, then saturate to 24 bits.
      prod = longint'(smp) * gain_q30;
      y = (prod + HALF_LSB) >>> 30;
      if (y > OUT_HI) begin
         y = OUT_HI;
      end
      if (y < OUT_LO) begin
         y = OUT_LO;
      end

      res.sample_out = y[lgrf_pkg::SAMPLE_W-1:0];
      res.gain_now = gain_q30[30:14];
      res.last = blk;
      pending_faded.push_back(res);
   endfunction

   // Every item accepted at this edge is run through the predictor.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_faded_sample(req_sample_in, req_target_gain, req_block_end);
      end
   end

   // Every result accepted at this edge is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_faded.size() == 0) begin
            $error("result item arrived with no prediction pending");
            error_count++;
         end else begin
            oldest_faded = pending_faded.pop_front();
            if (rsp_sample_out !== oldest_faded.sample_out) begin
               $error("sample_out: expected %0d, got %0d",
                      oldest_faded.sample_out, rsp_sample_out);
               error_count++;
            end
            if (rsp_gain_now !== oldest_faded.gain_now) begin
               $error("gain_now: expected %0d, got %0d", oldest_faded.gain_now, rsp_gain_now);
               error_count++;
            end
            if (rsp_last !== oldest_faded.last) begin
               $error("last: expected %0b, got %0b", oldest_faded.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Receiver side: a requested hold-off wins, otherwise random stall runs.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            if (rsp_idling && $urandom_range(0, 3) == 0) begin
               stall_left = random_gap_len();
            end
         end
      end
   end

   // Offers one item at a falling edge and holds it until the block takes it.
   task automatic send_item(input logic signed [lgrf_pkg::SAMPLE_W-1:0] smp,
                            input logic [lgrf_pkg::TARGET_W-1:0] tgt,
                            input logic blk);
      int gap;

      req_sample_in = smp;
      req_target_gain = tgt;
      req_block_end = blk;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      gap = (req_idling && $urandom_range(0, 2) == 0) ? random_gap_len() : 0;
      repeat (gap) @(negedge clock);
   endtask

   // Waits until every predicted item has come back and the pipe has emptied.
   task automatic drain_results();
      int waited;

      waited = 0;
      while (pending_faded.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);
   endtask

   // The rate register is only written while the block is idle.
   task automatic write_ramp_rate(input logic [lgrf_pkg::RATE_W-1:0] rate);
      drain_results();
      csr_wr_data = rate;
      csr_wr_en = 1'b1;
      fade_rate = rate;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic signed [lgrf_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return {1'b1, {(lgrf_pkg::SAMPLE_W-1){1'b0}}};
         1: return {1'b0, {(lgrf_pkg::SAMPLE_W-1){1'b1}}};
         2: return lgrf_pkg::SAMPLE_W'(int'($urandom_range(0, 3)) - 2);
         default: return lgrf_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [lgrf_pkg::TARGET_W-1:0] pick_target();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return lgrf_pkg::TARGET_MAX;
         2: return lgrf_pkg::TARGET_W'($urandom_range(65537, 131071));
         3: return lgrf_pkg::TARGET_W'($urandom_range(0, 16));
         4: return lgrf_pkg::TARGET_W'($urandom_range(0, 131071));
         default: return lgrf_pkg::TARGET_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // Right after reset the rate is 64; no register write precedes these items.
   task automatic test_reset_rate();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      send_item(24'sd8388607, lgrf_pkg::TARGET_MAX, 1'b0);
      send_item(-24'sd8388608, lgrf_pkg::TARGET_MAX, 1'b0);
      send_item(24'sd1, lgrf_pkg::TARGET_MAX, 1'b1);
   endtask

   // A repeated unity target keeps the slow step from before the rate change.
   // Targets above unity saturate and then compare equal to the held target.
   // The drop to zero at near-full rate lands just short and clamps one sample later.
   task automatic test_full_rate_and_targets();
      write_ramp_rate(16'hFFFF);
      send_item(24'sd8388607, lgrf_pkg::TARGET_MAX, 1'b0);
      send_item(-24'sd8388608, lgrf_pkg::TARGET_MAX, 1'b0);
      send_item(-24'sd1, lgrf_pkg::TARGET_MAX, 1'b0);
      send_item(24'sd0, lgrf_pkg::TARGET_MAX, 1'b1);
      send_item(-24'sd8388608, 17'h1FFFF, 1'b0);
      send_item(24'sd8388607, 17'd65537, 1'b0);
      send_item(24'sd8388607, 17'd0, 1'b0);
      send_item(-24'sd8388608, 17'd0, 1'b1);
   endtask

   // A zero rate gives a zero step, so the gain must not move.
   task automatic test_zero_rate();
      write_ramp_rate(16'd0);
      send_item(24'sd4194304, lgrf_pkg::TARGET_MAX, 1'b0);
      send_item(24'sd4194304, 17'd32768, 1'b1);
   endtask

   // The smallest rate truncates the step to zero, which becomes a unit step.
   task automatic test_min_step();
      write_ramp_rate(16'd1);
      send_item(24'sd8388607, 17'd1, 1'b0);
      send_item(24'sd8388607, 17'd1, 1'b0);
      send_item(-24'sd8388608, 17'd0, 1'b0);
      send_item(24'sd100, 17'd0, 1'b1);
   endtask

   // A repeated target keeps the step; a new one mid-ramp recomputes it.
   task automatic test_equal_target();
      write_ramp_rate(16'd4096);
      send_item(24'sd8388607, 17'd32768, 1'b0);
      send_item(24'sd8388607, 17'd32768, 1'b0);
      send_item(24'sd8388607, 17'd32768, 1'b0);
      send_item(-24'sd8388608, 17'd16384, 1'b0);
      send_item(-24'sd8388608, 17'd16384, 1'b1);
   endtask

   // The receiver holds off while the sender keeps offering back to back.
   task automatic test_backpressure();
      write_ramp_rate(16'd2048);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      hold_requests++;
      for (int k = 0; k < 40; k++) begin
         send_item(pick_sample(), (k < 20) ? lgrf_pkg::TARGET_MAX : 17'd8192, (k % 8) == 7);
      end
   endtask

   // Random ramps: a target is held for a run of samples, then replaced.
   task automatic test_random_ramps(input logic [lgrf_pkg::RATE_W-1:0] rate,
                                    input int n_items,
                                    input bit idle_on);
      int                            sent;
      int                            run_len;
      logic [lgrf_pkg::TARGET_W-1:0] tgt;

      write_ramp_rate(rate);
      req_idling = idle_on;
      rsp_idling = idle_on;
      sent = 0;
      while (sent < n_items) begin
         tgt = pick_target();
         run_len = ($urandom_range(0, 9) < 2) ? 1 : $urandom_range(2, 80);
         for (int k = 0; k < run_len && sent < n_items; k++) begin
            send_item(pick_sample(), tgt, $urandom_range(0, 15) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      test_reset_rate();
      test_full_rate_and_targets();
      test_zero_rate();
      test_min_step();
      test_equal_target();
      test_backpressure();

      test_random_ramps(lgrf_pkg::RATE_RESET, 160, 1'b1);
      test_random_ramps(16'hFFFF, 160, 1'b0);
      test_random_ramps(16'd0, 120, 1'b1);
      test_random_ramps(16'd1, 120, 1'b1);
      test_random_ramps(16'd32768, 160, 1'b1);
      test_random_ramps(lgrf_pkg::RATE_W'($urandom_range(1024, 65535)), 160, 1'b0);
      test_random_ramps(lgrf_pkg::RATE_W'($urandom_range(0, 65535)), 160, 1'b1);
      test_random_ramps(lgrf_pkg::RATE_W'($urandom_range(256, 4096)), 80, 1'b1);

      drain_results();
      if (pending_faded.size() != 0) begin
         $error("%0d predicted items never came back", pending_faded.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
